// ----- design/qhpw_pkg.sv -----
// ----------------------------------------------------------------------------
// qhpw_pkg: shared types, constants and microcode for the point warp block
// Holds the request and response words, the micro-instruction format, the
// register map of the working store and the microprogram for the build and
// transform sequences.
// ----------------------------------------------------------------------------
package qhpw_pkg;

   localparam int COORD_BITS = 16;
   localparam int DATA_BITS  = 64;
   localparam int RADDR_BITS = 6;
   localparam int PC_BITS    = 8;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BUILD = 2'd1,
      MODE_XFORM = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         corner_index;
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
   } req_type;

   typedef struct packed {
      logic signed [63:0] out_x;
      logic signed [63:0] out_y;
      logic               ok;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_BNZ, OP_JMP,
      OP_CLROK, OP_BANK, OP_OUTX, OP_OUTY, OP_END
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [RADDR_BITS-1:0] dst;
      logic [RADDR_BITS-1:0] src_a;
      logic [RADDR_BITS-1:0] src_b;
      logic [PC_BITS-1:0]    target;
   } uinst_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } alu_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_RDB, ST_EXEC, ST_WAIT, ST_DONE
   } state_type;

   // working store map
   localparam int R_CY   = 8;
   localparam int R_W    = 16;
   localparam int R_X    = 25;
   localparam int R_Y    = 26;
   localparam int R_ZERO = 27;
   localparam int R_ONE  = 28;
   localparam int R_S    = 29;
   localparam int R_D    = 38;
   localparam int R_I    = 47;
   localparam int R_T    = 56;

   localparam int PC_PROJ  = 16;
   localparam int PC_DIVP  = 30;
   localparam int PC_FORM  = 38;
   localparam int PC_ADJ   = 54;
   localparam int PC_MM    = 81;
   localparam int PC_XFORM = 127;
   localparam int PC_XDIV  = 136;
   localparam int PROG_LEN = 149;

   typedef uinst_type [0:PROG_LEN-1] prog_type;

   function automatic uinst_type mk(op_type op, int d, int a, int b, int t);
      uinst_type u;
      u.op     = op;
      u.dst    = RADDR_BITS'(d);
      u.src_a  = RADDR_BITS'(a);
      u.src_b  = RADDR_BITS'(b);
      u.target = PC_BITS'(t);
      return u;
   endfunction

   function automatic prog_type build_prog();
      prog_type p;
      int ja[9];
      int jb[9];
      int jc[9];
      int jd[9];
      int k;
      int i;
      int j;
      ja = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
      jb = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
      jc = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
      jd = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
      p = '{default: '0};
      // square to quad, corners a..d at 0..3 (x) and 8..11 (y)
      p[0]  = mk(OP_SUB, R_T, 11, 10, 0);
      p[1]  = mk(OP_SUB, R_T+1, 8, 9, 0);
      p[2]  = mk(OP_ADD, R_T+1, R_T+1, 10, 0);
      p[3]  = mk(OP_SUB, R_T+1, R_T+1, 11, 0);
      p[4]  = mk(OP_BNZ, 0, R_T, 0, PC_PROJ);
      p[5]  = mk(OP_BNZ, 0, R_T+1, 0, PC_PROJ);
      p[6]  = mk(OP_SUB, R_S, 1, 0, 0);
      p[7]  = mk(OP_SUB, R_S+1, 2, 1, 0);
      p[8]  = mk(OP_ADD, R_S+2, 0, R_ZERO, 0);
      p[9]  = mk(OP_SUB, R_S+3, 9, 8, 0);
      p[10] = mk(OP_SUB, R_S+4, 10, 9, 0);
      p[11] = mk(OP_ADD, R_S+5, 8, R_ZERO, 0);
      p[12] = mk(OP_ADD, R_S+6, R_ZERO, R_ZERO, 0);
      p[13] = mk(OP_ADD, R_S+7, R_ZERO, R_ZERO, 0);
      p[14] = mk(OP_ADD, R_S+8, R_ONE, R_ZERO, 0);
      p[15] = mk(OP_BANK, 0, 0, 0, PC_ADJ);
      p[16] = mk(OP_SUB, R_T+2, 1, 2, 0);
      p[17] = mk(OP_SUB, R_T+3, 3, 2, 0);
      p[18] = mk(OP_SUB, R_T+4, 0, 1, 0);
      p[19] = mk(OP_ADD, R_T+4, R_T+4, 2, 0);
      p[20] = mk(OP_SUB, R_T+4, R_T+4, 3, 0);
      p[21] = mk(OP_SUB, R_T+5, 9, 10, 0);
      p[22] = mk(OP_MUL, R_T+6, R_T+2, R_T, 0);
      p[23] = mk(OP_MUL, R_T+7, R_T+3, R_T+5, 0);
      p[24] = mk(OP_SUB, R_T+6, R_T+6, R_T+7, 0);
      p[25] = mk(OP_BNZ, 0, R_T+6, 0, PC_DIVP);
      p[26] = mk(OP_CLROK, 0, 0, 0, 0);
      p[27] = mk(OP_ADD, R_S+6, R_ZERO, R_ZERO, 0);
      p[28] = mk(OP_ADD, R_S+7, R_ZERO, R_ZERO, 0);
      p[29] = mk(OP_JMP, 0, 0, 0, PC_FORM);
      p[30] = mk(OP_MUL, R_T+7, R_T+4, R_T, 0);
      p[31] = mk(OP_MUL, R_S+6, R_T+3, R_T+1, 0);
      p[32] = mk(OP_SUB, R_T+7, R_T+7, R_S+6, 0);
      p[33] = mk(OP_DIV, R_S+6, R_T+7, R_T+6, 0);
      p[34] = mk(OP_MUL, R_T+7, R_T+2, R_T+1, 0);
      p[35] = mk(OP_MUL, R_S+7, R_T+4, R_T+5, 0);
      p[36] = mk(OP_SUB, R_T+7, R_T+7, R_S+7, 0);
      p[37] = mk(OP_DIV, R_S+7, R_T+7, R_T+6, 0);
      p[38] = mk(OP_MUL, R_T+7, R_S+6, 1, 0);
      p[39] = mk(OP_SUB, R_T, 1, 0, 0);
      p[40] = mk(OP_ADD, R_S, R_T, R_T+7, 0);
      p[41] = mk(OP_MUL, R_T+7, R_S+7, 3, 0);
      p[42] = mk(OP_SUB, R_T, 3, 0, 0);
      p[43] = mk(OP_ADD, R_S+1, R_T, R_T+7, 0);
      p[44] = mk(OP_ADD, R_S+2, 0, R_ZERO, 0);
      p[45] = mk(OP_MUL, R_T+7, R_S+6, 9, 0);
      p[46] = mk(OP_SUB, R_T, 9, 8, 0);
      p[47] = mk(OP_ADD, R_S+3, R_T, R_T+7, 0);
      p[48] = mk(OP_MUL, R_T+7, R_S+7, 11, 0);
      p[49] = mk(OP_SUB, R_T, 11, 8, 0);
      p[50] = mk(OP_ADD, R_S+4, R_T, R_T+7, 0);
      p[51] = mk(OP_ADD, R_S+5, 8, R_ZERO, 0);
      p[52] = mk(OP_ADD, R_S+8, R_ONE, R_ZERO, 0);
      p[53] = mk(OP_BANK, 0, 0, 0, PC_ADJ);
      // adjoint of source matrix
      for (k = 0; k < 9; k++) begin
         p[PC_ADJ+3*k]   = mk(OP_MUL, R_T, R_S+ja[k], R_S+jb[k], 0);
         p[PC_ADJ+3*k+1] = mk(OP_MUL, R_T+1, R_S+jc[k], R_S+jd[k], 0);
         p[PC_ADJ+3*k+2] = mk(OP_SUB, R_I+k, R_T, R_T+1, 0);
      end
      // destination times adjoint
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            k = PC_MM + 5*(i*3+j);
            p[k]   = mk(OP_MUL, R_T, R_D+i*3, R_I+j, 0);
            p[k+1] = mk(OP_MUL, R_T+1, R_D+i*3+1, R_I+3+j, 0);
            p[k+2] = mk(OP_ADD, R_T, R_T, R_T+1, 0);
            p[k+3] = mk(OP_MUL, R_T+1, R_D+i*3+2, R_I+6+j, 0);
            p[k+4] = mk(OP_ADD, R_W+i*3+j, R_T, R_T+1, 0);
         end
      end
      p[126] = mk(OP_END, 0, 0, 0, 0);
      // point transform
      p[127] = mk(OP_MUL, R_T, R_W+6, R_X, 0);
      p[128] = mk(OP_MUL, R_T+1, R_W+7, R_Y, 0);
      p[129] = mk(OP_ADD, R_T, R_T, R_T+1, 0);
      p[130] = mk(OP_ADD, R_T, R_T, R_W+8, 0);
      p[131] = mk(OP_BNZ, 0, R_T, 0, PC_XDIV);
      p[132] = mk(OP_CLROK, 0, 0, 0, 0);
      p[133] = mk(OP_OUTX, 0, R_X, 0, 0);
      p[134] = mk(OP_OUTY, 0, R_Y, 0, 0);
      p[135] = mk(OP_END, 0, 0, 0, 0);
      p[136] = mk(OP_MUL, R_T+1, R_W, R_X, 0);
      p[137] = mk(OP_MUL, R_T+2, R_W+1, R_Y, 0);
      p[138] = mk(OP_ADD, R_T+1, R_T+1, R_T+2, 0);
      p[139] = mk(OP_ADD, R_T+1, R_T+1, R_W+2, 0);
      p[140] = mk(OP_DIV, R_T+1, R_T+1, R_T, 0);
      p[141] = mk(OP_OUTX, 0, R_T+1, 0, 0);
      p[142] = mk(OP_MUL, R_T+1, R_W+3, R_X, 0);
      p[143] = mk(OP_MUL, R_T+2, R_W+4, R_Y, 0);
      p[144] = mk(OP_ADD, R_T+1, R_T+1, R_T+2, 0);
      p[145] = mk(OP_ADD, R_T+1, R_T+1, R_W+5, 0);
      p[146] = mk(OP_DIV, R_T+1, R_T+1, R_T, 0);
      p[147] = mk(OP_OUTY, 0, R_T+1, 0, 0);
      p[148] = mk(OP_END, 0, 0, 0, 0);
      return p;
   endfunction

   localparam prog_type PROG = build_prog();

   // second corner set: shift corner slots by four, source matrix to destination
   function automatic logic [RADDR_BITS-1:0] remap(logic [RADDR_BITS-1:0] a, logic bank);
      logic [RADDR_BITS-1:0] r;
      r = a;
      if (bank) begin
         if (a < RADDR_BITS'(4) || (a >= RADDR_BITS'(R_CY) && a < RADDR_BITS'(R_CY+4)))
            r = a + RADDR_BITS'(4);
         else if (a >= RADDR_BITS'(R_S) && a < RADDR_BITS'(R_D))
            r = a + RADDR_BITS'(R_D-R_S);
      end
      return r;
   endfunction

endpackage

// ----- design/qhpw_alu.sv -----
// ----------------------------------------------------------------------------
// qhpw_alu: shared multiply and divide unit
// Low 64 bits of a product from one 32x32 multiplier, summing low and cross partial products;
// signed truncating quotient by a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module qhpw_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  qhpw_pkg::alu_ctl_type       ctl,
   input  logic [63:0]                 opa,
   input  logic [63:0]                 opb,
   output logic                        done,
   output logic [63:0]                 result
);

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [64:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [31:0] mx, my;
   logic [63:0] prod;
   logic [64:0] shl;

   assign prod = mx * my;
   assign shl  = {rem_ff[63:0], acc_ff[63]};

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      mx      = a_ff[31:0];
      my      = b_ff[31:0];
      if (cnt_ff == 7'd1) begin
         my = b_ff[63:32];
      end else if (cnt_ff == 7'd2) begin
         mx = a_ff[63:32];
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.is_div;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = opa[63] ^ opb[63];
         if (ctl.is_div) begin
            a_in   = opa[63] ? (64'd0 - opa) : opa;
            b_in   = opb[63] ? (64'd0 - opb) : opb;
            acc_in = opa[63] ? (64'd0 - opa) : opa;
         end else begin
            a_in   = opa;
            b_in   = opb;
            acc_in = '0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (!div_ff) begin
            if (cnt_ff == 7'd0) begin
               acc_in = prod;
            end else begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
            end
            if (cnt_ff == 7'd2) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else if (cnt_ff == 7'd64) begin
            acc_in  = neg_ff ? (64'd0 - acc_ff) : acc_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (shl >= {1'b0, b_ff}) begin
            rem_in = shl - {1'b0, b_ff};
            acc_in = {acc_ff[62:0], 1'b1};
         end else begin
            rem_in = shl;
            acc_in = {acc_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ----- design/qhpw_regs.sv -----
// ----------------------------------------------------------------------------
// qhpw_regs: working store for matrices and intermediates
// One write and one registered read a cycle; entries never written read zero.
// ----------------------------------------------------------------------------
module qhpw_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [qhpw_pkg::RADDR_BITS-1:0]   wr_addr,
   input  logic [63:0]                       wr_data,
   input  logic [qhpw_pkg::RADDR_BITS-1:0]   rd_addr,
   output logic [63:0]                       rd_data
);

   localparam int DEPTH = 1 << qhpw_pkg::RADDR_BITS;

   logic [63:0]      mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [63:0]      data_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[rd_addr];
      hit_ff  <= valid_ff[rd_addr];
   end

   assign rd_data = hit_ff ? data_ff : 64'd0;

endmodule

// ----- design/quad_homography_point_warp.sv -----
// ----------------------------------------------------------------------------
// quad_homography_point_warp: integer 3x3 perspective transform
// Corner loads, matrix build and point transform under a microcoded sequencer
// that drives one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// A load or an unused mode returns its word in the cycle right after the
// accepting edge. A build runs 105 to 153 micro-instructions, depending on the
// shape of each corner set; a transform skips both divisions when the divisor
// is zero. Each micro-instruction passes through the fetch, second-read and
// execute states for its two reads through the single port of the working
// store; a multiply also waits on the shared 32x32 multiplier and a divide on
// the one-bit-per-cycle divider. busy is high from the accepting edge until
// the result cycle ends; the receiver cannot stall, and rsp_valid marks the
// single cycle in which rsp_word must be taken.
// ----------------------------------------------------------------------------
module quad_homography_point_warp (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qhpw_pkg::req_type   req_word,
   output logic                rsp_valid,
   output qhpw_pkg::rsp_type   rsp_word
);

   localparam int CB = qhpw_pkg::COORD_BITS;
   localparam int AB = qhpw_pkg::RADDR_BITS;
   localparam int PB = qhpw_pkg::PC_BITS;

   qhpw_pkg::state_type   state_ff, state_in;
   logic [PB-1:0]         pc_ff, pc_in;
   logic                  bank_ff, bank_in;
   logic                  ok_ff, ok_in;
   logic [63:0]           outx_ff, outx_in;
   logic [63:0]           outy_ff, outy_in;
   logic [63:0]           opa_ff, opa_in;
   logic [CB-1:0]         px_ff, px_in;
   logic [CB-1:0]         py_ff, py_in;
   logic [CB-1:0]         cx_ff [8];
   logic [CB-1:0]         cy_ff [8];
   logic [AB-1:0]         sel_ff;
   logic                  accept;
   qhpw_pkg::uinst_type   inst;
   logic [AB-1:0]         rd_addr;
   logic                  wr_en;
   logic [AB-1:0]         wr_addr;
   logic [63:0]           wr_data;
   logic [63:0]           mem_data;
   logic [63:0]           operand;
   qhpw_pkg::alu_ctl_type alu_ctl;
   logic                  alu_done;
   logic [63:0]           alu_result;

   assign accept = start && !busy;
   assign inst   = qhpw_pkg::PROG[pc_ff];

   qhpw_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (mem_data)
   );

   qhpw_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (opa_ff),
      .opb    (operand),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      if (sel_ff < AB'(qhpw_pkg::R_CY)) begin
         operand = {{(64-CB){cx_ff[sel_ff[2:0]][CB-1]}}, cx_ff[sel_ff[2:0]]};
      end else if (sel_ff < AB'(qhpw_pkg::R_W)) begin
         operand = {{(64-CB){cy_ff[sel_ff[2:0]][CB-1]}}, cy_ff[sel_ff[2:0]]};
      end else if (sel_ff == AB'(qhpw_pkg::R_X)) begin
         operand = {{(64-CB){px_ff[CB-1]}}, px_ff};
      end else if (sel_ff == AB'(qhpw_pkg::R_Y)) begin
         operand = {{(64-CB){py_ff[CB-1]}}, py_ff};
      end else if (sel_ff == AB'(qhpw_pkg::R_ZERO)) begin
         operand = 64'd0;
      end else if (sel_ff == AB'(qhpw_pkg::R_ONE)) begin
         operand = 64'd1;
      end else begin
         operand = mem_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      bank_in  = bank_ff;
      ok_in    = ok_ff;
      outx_in  = outx_ff;
      outy_in  = outy_ff;
      opa_in   = opa_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      rd_addr  = qhpw_pkg::remap(inst.src_a, bank_ff);
      wr_en    = 1'b0;
      wr_addr  = qhpw_pkg::remap(inst.dst, bank_ff);
      wr_data  = alu_result;
      alu_ctl  = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         qhpw_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ok_in   = 1'b1;
               outx_in = '0;
               outy_in = '0;
               bank_in = 1'b0;
               px_in   = req_word.x_coord[CB-1:0];
               py_in   = req_word.y_coord[CB-1:0];
               unique case (qhpw_pkg::mode_type'(req_word.mode))
                  qhpw_pkg::MODE_BUILD: begin
                     pc_in    = '0;
                     state_in = qhpw_pkg::ST_FETCH;
                  end
                  qhpw_pkg::MODE_XFORM: begin
                     pc_in    = PB'(qhpw_pkg::PC_XFORM);
                     state_in = qhpw_pkg::ST_FETCH;
                  end
                  qhpw_pkg::MODE_LOAD,
                  qhpw_pkg::MODE_NONE: begin
                     state_in = qhpw_pkg::ST_DONE;
                  end
               endcase
            end
         end
         qhpw_pkg::ST_FETCH: begin
            state_in = qhpw_pkg::ST_RDB;
         end
         qhpw_pkg::ST_RDB: begin
            opa_in   = operand;
            rd_addr  = qhpw_pkg::remap(inst.src_b, bank_ff);
            state_in = qhpw_pkg::ST_EXEC;
         end
         qhpw_pkg::ST_EXEC: begin
            pc_in    = pc_ff + PB'(1);
            state_in = qhpw_pkg::ST_FETCH;
            unique case (inst.op)
               qhpw_pkg::OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = opa_ff + operand;
               end
               qhpw_pkg::OP_SUB: begin
                  wr_en   = 1'b1;
                  wr_data = opa_ff - operand;
               end
               qhpw_pkg::OP_MUL,
               qhpw_pkg::OP_DIV: begin
                  alu_ctl.start  = 1'b1;
                  alu_ctl.is_div = (inst.op == qhpw_pkg::OP_DIV);
                  pc_in          = pc_ff;
                  state_in       = qhpw_pkg::ST_WAIT;
               end
               qhpw_pkg::OP_BNZ: begin
                  if (opa_ff != 64'd0) begin
                     pc_in = inst.target;
                  end
               end
               qhpw_pkg::OP_JMP: begin
                  pc_in = inst.target;
               end
               qhpw_pkg::OP_CLROK: begin
                  ok_in = 1'b0;
               end
               qhpw_pkg::OP_BANK: begin
                  if (!bank_ff) begin
                     bank_in = 1'b1;
                     pc_in   = '0;
                  end else begin
                     bank_in = 1'b0;
                     pc_in   = inst.target;
                  end
               end
               qhpw_pkg::OP_OUTX: begin
                  outx_in = opa_ff;
               end
               qhpw_pkg::OP_OUTY: begin
                  outy_in = opa_ff;
               end
               qhpw_pkg::OP_END: begin
                  state_in = qhpw_pkg::ST_DONE;
               end
               default: begin
                  state_in = qhpw_pkg::ST_DONE;
               end
            endcase
         end
         qhpw_pkg::ST_WAIT: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               pc_in    = pc_ff + PB'(1);
               state_in = qhpw_pkg::ST_FETCH;
            end
         end
         qhpw_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = qhpw_pkg::ST_IDLE;
         end
         default: begin
            state_in = qhpw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qhpw_pkg::ST_IDLE;
         pc_ff    <= '0;
         bank_ff  <= 1'b0;
         ok_ff    <= 1'b1;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         bank_ff  <= bank_in;
         ok_ff    <= ok_in;
      end
      outx_ff <= outx_in;
      outy_ff <= outy_in;
      opa_ff  <= opa_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      sel_ff  <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
         end
      end else if (accept &&
                   qhpw_pkg::mode_type'(req_word.mode) == qhpw_pkg::MODE_LOAD) begin
         cx_ff[req_word.corner_index] <= req_word.x_coord[CB-1:0];
         cy_ff[req_word.corner_index] <= req_word.y_coord[CB-1:0];
      end
   end

   assign rsp_word.out_x = outx_ff;
   assign rsp_word.out_y = outy_ff;
   assign rsp_word.ok    = ok_ff;

endmodule
